FILE: hdl/assert_macros.svh
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, off while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication form: antecedent (may be a sequence) implies consequent.
`define ASSERT_IMP(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

FILE: hdl/edd_pkg.sv
// Shared types, constants and arithmetic helpers of the error diffusion dither.
`timescale 1ns / 1ps

package edd_pkg;

	localparam int MAX_WIDTH_DEF = 1024;

	localparam int CFG_AW  = 4;
	localparam int CFG_DW  = 32;
	localparam int IMG_W_W = 11;
	localparam int PIX_W   = 8;
	localparam int ERR_W   = 9;

	localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST    = 11'd640;
	localparam logic [PIX_W-1:0]   GRAY_THRESHOLD_RST = 8'd120;
	localparam logic [PIX_W-1:0]   LOW_LEVEL_RST      = 8'd28;
	localparam logic [PIX_W-1:0]   HIGH_LEVEL_RST     = 8'd255;

	// divide by 3 as (sum * 683) >> 11, exact for sums up to 765
	localparam int GRAY_SUM_W  = 10;
	localparam int GRAY_PROD_W = 20;
	localparam logic [GRAY_PROD_W-1:0] GRAY_RECIP = 20'd683;
	localparam int GRAY_SHIFT  = 11;

	// rows this short need write-back before the next read
	localparam int NARROW_LAST = 2;

	// output queue, power-of-two depth
	localparam int OUT_FIFO_DEPTH = 4;
	localparam int FIFO_PW = $clog2(OUT_FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(OUT_FIFO_DEPTH + 1);

	// share weights, in sixteenths
	localparam logic [2:0] SHARE_ABOVE_LEFT  = 3'd1;
	localparam logic [2:0] SHARE_ABOVE       = 3'd5;
	localparam logic [2:0] SHARE_ABOVE_RIGHT = 3'd3;
	localparam logic [2:0] SHARE_LEFT        = 3'd7;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH    = 2'd0,
		REG_GRAY_THRESHOLD = 2'd1,
		REG_LOW_LEVEL      = 2'd2,
		REG_HIGH_LEVEL     = 2'd3
	} edd_reg_t;

	typedef struct packed {
		logic             valid;
		logic             first_row;
		logic             has_left;
		logic             is_end;
		logic [PIX_W-1:0] gray;
	} edd_ctl_t;

	typedef struct packed {
		logic [PIX_W-1:0] level;
		logic             row_end;
	} edd_res_t;

	// floor((k * err) / 16)
	function automatic logic signed [7:0] share_of(input logic [2:0] k,
			input logic signed [ERR_W-1:0] err);
		logic signed [11:0] p;
		p = 12'($signed({1'b0, k})) * 12'(err);
		return p[11:4];
	endfunction

	// add, then clamp: upper bound tested first
	function automatic logic [PIX_W-1:0] add_clamp(input logic [PIX_W-1:0] v,
			input logic signed [7:0] s, input logic [PIX_W-1:0] lo,
			input logic [PIX_W-1:0] hi);
		logic signed [9:0] n;
		n = $signed({2'b00, v}) + $signed({{2{s[7]}}, s});
		if (n > $signed({2'b00, hi})) begin
			return hi;
		end else if (n < $signed({2'b00, lo})) begin
			return lo;
		end else begin
			return n[PIX_W-1:0];
		end
	endfunction

endpackage

FILE: hdl/edd_line_mem.sv
// Line store of pixel errors: one write port, two registered read ports.
`timescale 1ns / 1ps

module edd_line_mem #(
	parameter int DEPTH  = edd_pkg::MAX_WIDTH_DEF,
	parameter int ADDR_W = $clog2(edd_pkg::MAX_WIDTH_DEF)
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [ADDR_W-1:0]                wr_addr,
	input  logic signed [edd_pkg::ERR_W-1:0] wr_data,
	input  logic                             rd_en,
	input  logic [ADDR_W-1:0]                rd_addr_a,
	input  logic [ADDR_W-1:0]                rd_addr_b,
	output logic signed [edd_pkg::ERR_W-1:0] rd_data_a,
	output logic signed [edd_pkg::ERR_W-1:0] rd_data_b
);
	import edd_pkg::*;

	logic signed [ERR_W-1:0] mem [DEPTH];

	// read-first: a read at the write address returns the old entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

FILE: hdl/edd_out_fifo.sv
// Small output queue that decouples the pipeline from the result stall.
`timescale 1ns / 1ps

module edd_out_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  edd_pkg::edd_res_t            push_data,
	output logic                         valid,
	input  logic                         stall,
	output edd_pkg::edd_res_t            data,
	output logic [edd_pkg::FIFO_CW-1:0]  count
);
	import edd_pkg::*;

	edd_res_t           entry_q [OUT_FIFO_DEPTH];
	logic [FIFO_PW-1:0] wr_ptr_q;
	logic [FIFO_PW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               pop;

	assign valid = (count_q != '0);
	assign data  = entry_q[rd_ptr_q];
	assign count = count_q;
	assign pop   = valid && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: hdl/edd_diffuse.sv
// Two-stage error diffusion datapath: shares from above, then left share and threshold.
`timescale 1ns / 1ps

module edd_diffuse #(
	parameter int ADDR_W = $clog2(edd_pkg::MAX_WIDTH_DEF)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  edd_pkg::edd_ctl_t                ctl,
	input  logic [ADDR_W-1:0]                col,
	input  logic signed [edd_pkg::ERR_W-1:0] above_err,
	input  logic signed [edd_pkg::ERR_W-1:0] above_right_err,
	input  logic [edd_pkg::PIX_W-1:0]        gray_threshold,
	input  logic [edd_pkg::PIX_W-1:0]        low_level,
	input  logic [edd_pkg::PIX_W-1:0]        high_level,
	output logic                             wr_en,
	output logic [ADDR_W-1:0]                wr_addr,
	output logic signed [edd_pkg::ERR_W-1:0] wr_err,
	output logic                             res_valid,
	output edd_pkg::edd_res_t                res,
	output logic [1:0]                       busy_cnt
);
	import edd_pkg::*;

	// stage 1: line store data arrives
	edd_ctl_t                ctl_s1;
	logic [ADDR_W-1:0]       col_s1;
	logic signed [ERR_W-1:0] above_left_q;
	logic signed [ERR_W-1:0] above;
	logic [PIX_W-1:0]        v1;

	// stage 2: left share, threshold, write-back
	logic                    valid_s2;
	logic                    has_left_s2;
	logic                    is_end_s2;
	logic [ADDR_W-1:0]       col_s2;
	logic [PIX_W-1:0]        v_s2;
	logic signed [ERR_W-1:0] left_err_q;
	logic [PIX_W-1:0]        v2;
	logic [PIX_W-1:0]        lvl;
	logic signed [ERR_W-1:0] err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			ctl_s1   <= ctl;
			valid_s2 <= ctl_s1.valid;
		end
	end

	always_comb begin
		above = ctl_s1.first_row ? '0 : above_err;
		v1    = ctl_s1.gray;
		if (!ctl_s1.first_row) begin
			if (ctl_s1.has_left) begin
				v1 = add_clamp(v1, share_of(SHARE_ABOVE_LEFT, above_left_q),
					low_level, high_level);
			end
			v1 = add_clamp(v1, share_of(SHARE_ABOVE, above_err), low_level, high_level);
			if (!ctl_s1.is_end) begin
				v1 = add_clamp(v1, share_of(SHARE_ABOVE_RIGHT, above_right_err),
					low_level, high_level);
			end
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= col;
		if (ctl_s1.valid) begin
			above_left_q <= above;
			v_s2         <= v1;
			has_left_s2  <= ctl_s1.has_left;
			is_end_s2    <= ctl_s1.is_end;
			col_s2       <= col_s1;
		end
		if (valid_s2) begin
			left_err_q <= err;
		end
	end

	always_comb begin
		v2  = has_left_s2 ? add_clamp(v_s2, share_of(SHARE_LEFT, left_err_q),
			low_level, high_level) : v_s2;
		lvl = (v2 < gray_threshold) ? low_level : high_level;
		err = $signed({1'b0, v2}) - $signed({1'b0, lvl});
	end

	assign wr_en       = valid_s2;
	assign wr_addr     = col_s2;
	assign wr_err      = err;
	assign res_valid   = valid_s2;
	assign res.level   = lvl;
	assign res.row_end = is_end_s2;
	assign busy_cnt    = {1'b0, ctl_s1.valid} + {1'b0, valid_s2};

endmodule

FILE: hdl/error_diffusion_dither.sv
// Top level of the error diffusion dither: config registers, column control, line store.
//
//   channel | handshake               | payload
//   --------+-------------------------+-----------------------------
//   pixel   | pix_valid / pix_stall   | red, green, blue, frame_start
//   result  | dith_valid / dith_stall | level, row_end
//   config  | APB psel/penable/pready | paddr, pwdata, prdata
//
// One pixel per clock while pix_stall is low; a result passes stage 1, stage 2 and the
// output queue before it leaves. The line store is read at transfer, ahead of its stage 2
// write-back, so rows of three pixels or fewer stall each pixel until the pipeline drains.
// pix_stall follows the four-deep output queue plus the two pipeline stages, and that drain.
// Async active-low reset clears control state; the line store is not cleared.
`timescale 1ns / 1ps

module error_diffusion_dither #(
	parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// pixel in
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  logic [edd_pkg::PIX_W-1:0]     red,
	input  logic [edd_pkg::PIX_W-1:0]     green,
	input  logic [edd_pkg::PIX_W-1:0]     blue,
	input  logic                          frame_start,
	// result out
	output logic                          dith_valid,
	input  logic                          dith_stall,
	output logic [edd_pkg::PIX_W-1:0]     level,
	output logic                          row_end,
	// config
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [edd_pkg::CFG_AW-1:0]    paddr,
	input  logic [edd_pkg::CFG_DW-1:0]    pwdata,
	output logic [edd_pkg::CFG_DW-1:0]    prdata,
	output logic                          pready
);
	import edd_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	// config registers
	logic [IMG_W_W-1:0] image_width_q;
	logic [PIX_W-1:0]   gray_threshold_q;
	logic [PIX_W-1:0]   low_level_q;
	logic [PIX_W-1:0]   high_level_q;
	logic               cfg_wr;
	edd_reg_t           reg_sel;

	// column tracking
	logic [AW-1:0]      column_q;
	logic               first_row_q;
	logic [AW-1:0]      last_col;
	logic [AW-1:0]      col_base;
	logic [AW-1:0]      col;
	logic [AW-1:0]      col_plus;
	logic               is_end;
	logic               first_row;
	logic               narrow;
	logic               accept;

	// gray conversion
	logic [GRAY_SUM_W-1:0]  gray_sum;
	logic [GRAY_PROD_W-1:0] gray_prod;

	edd_ctl_t                ctl;
	logic signed [ERR_W-1:0] rd_a;
	logic signed [ERR_W-1:0] rd_b;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic signed [ERR_W-1:0] wr_err;
	logic                    res_valid;
	edd_res_t                res;
	edd_res_t                head;
	logic [1:0]              busy_cnt;
	logic [FIFO_CW-1:0]      fifo_count;
	logic [FIFO_CW:0]        inflight;

	// ---- APB register file, zero wait states ----
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = edd_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q    <= IMAGE_WIDTH_RST;
			gray_threshold_q <= GRAY_THRESHOLD_RST;
			low_level_q      <= LOW_LEVEL_RST;
			high_level_q     <= HIGH_LEVEL_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_IMAGE_WIDTH:    image_width_q    <= pwdata[IMG_W_W-1:0];
				REG_GRAY_THRESHOLD: gray_threshold_q <= pwdata[PIX_W-1:0];
				REG_LOW_LEVEL:      low_level_q      <= pwdata[PIX_W-1:0];
				REG_HIGH_LEVEL:     high_level_q     <= pwdata[PIX_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_IMAGE_WIDTH:    prdata = CFG_DW'(image_width_q);
			REG_GRAY_THRESHOLD: prdata = CFG_DW'(gray_threshold_q);
			REG_LOW_LEVEL:      prdata = CFG_DW'(low_level_q);
			REG_HIGH_LEVEL:     prdata = CFG_DW'(high_level_q);
		endcase
	end

	// ---- last column: width 0 acts as 1, width above MAX_WIDTH saturates ----
	always_comb begin
		if (image_width_q == '0) begin
			last_col = '0;
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			last_col = AW'(MAX_WIDTH - 1);
		end else begin
			last_col = AW'(image_width_q - 11'd1);
		end
	end

	assign narrow = (32'(last_col) <= 32'(NARROW_LAST));

	// ---- input flow control ----
	// Credit check: everything in the pipeline must fit in the output queue.
	// Short rows also wait until the last write-back has landed.
	assign inflight  = (FIFO_CW + 1)'(busy_cnt) + (FIFO_CW + 1)'(fifo_count);
	assign pix_stall = (inflight >= (FIFO_CW + 1)'(OUT_FIFO_DEPTH)) ||
		(narrow && (busy_cnt != 2'd0));
	assign accept    = pix_valid && !pix_stall;

	// ---- column of this pixel; frame start restarts at the first row ----
	assign col_base  = frame_start ? '0 : column_q;
	assign first_row = frame_start ? 1'b1 : first_row_q;
	assign col       = (col_base > last_col) ? last_col : col_base;
	assign is_end    = (col == last_col);
	assign col_plus  = col + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			first_row_q <= 1'b1;
		end else if (accept) begin
			column_q    <= is_end ? '0 : col_plus;
			first_row_q <= is_end ? 1'b0 : first_row;
		end
	end

	// ---- gray = (r + g + b) / 3 via reciprocal multiply ----
	assign gray_sum  = GRAY_SUM_W'(red) + GRAY_SUM_W'(green) + GRAY_SUM_W'(blue);
	assign gray_prod = GRAY_PROD_W'(gray_sum) * GRAY_RECIP;

	assign ctl.valid     = accept;
	assign ctl.first_row = first_row;
	assign ctl.has_left  = (col != '0);
	assign ctl.is_end    = is_end;
	assign ctl.gray      = gray_prod[GRAY_SHIFT +: PIX_W];

	// line store: read above and above-right at transfer, error written back in stage 2
	edd_line_mem #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (AW)
	) u_line_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_err),
		.rd_en     (accept),
		.rd_addr_a (col),
		.rd_addr_b (col_plus),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	edd_diffuse #(
		.ADDR_W (AW)
	) u_diffuse (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.col             (col),
		.above_err       (rd_a),
		.above_right_err (rd_b),
		.gray_threshold  (gray_threshold_q),
		.low_level       (low_level_q),
		.high_level      (high_level_q),
		.wr_en           (wr_en),
		.wr_addr         (wr_addr),
		.wr_err          (wr_err),
		.res_valid       (res_valid),
		.res             (res),
		.busy_cnt        (busy_cnt)
	);

	// output queue keeps results while dith_stall is high
	edd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.valid     (dith_valid),
		.stall     (dith_stall),
		.data      (head),
		.count     (fifo_count)
	);

	assign level   = head.level;
	assign row_end = head.row_end;

endmodule

FILE: hdl/edd_checker.sv
// Port-level checker for the error diffusion dither, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module edd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pix_valid,
	input logic                       pix_stall,
	input logic                       dith_valid,
	input logic                       dith_stall,
	input logic [edd_pkg::PIX_W-1:0]  level,
	input logic                       row_end,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [edd_pkg::CFG_AW-1:0] paddr,
	input logic [edd_pkg::CFG_DW-1:0] pwdata,
	input logic [edd_pkg::CFG_DW-1:0] prdata
);

	// a stalled result stays offered
	`ASSERT_IMP(a_res_hold, dith_valid && dith_stall, ##1 dith_valid, "result dropped while stalled")

	// a stalled result keeps its payload
	`ASSERT_IMP(a_res_stable, dith_valid && dith_stall, ##1 ($stable(level) && $stable(row_end)), "result changed while stalled")

	// nothing queued and no transfer still in stage 1 or stage 2: the pipeline is empty and must take a pixel
	`ASSERT_IMP(a_idle_takes, !dith_valid && !$past(pix_valid && !pix_stall) && !$past(pix_valid && !pix_stall, 2), !pix_stall, "stall while pipeline empty")

	// register readback right after a write
	`ASSERT_IMP(a_cfg_readback, (psel && penable && pwrite) ##1 (psel && !pwrite && (paddr == $past(paddr))), prdata[7:0] == $past(pwdata[7:0]), "register readback mismatch")

endmodule

bind error_diffusion_dither edd_checker u_edd_checker (.*);
